// ===== rtl/rmc_pkg.sv =====
`default_nettype none

package rmc_pkg;

   localparam int unsigned COUNT_WIDTH         = 33;
   localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

   // operation codes of the shared arithmetic unit
   typedef enum logic [1:0] {
      OP_DIV = 2'd0,
      OP_MUL = 2'd1,
      OP_GCD = 2'd2
   } arith_op_type;

   typedef struct packed {
      logic         go;
      arith_op_type op;
   } arith_req_type;

endpackage

`default_nettype wire

// ===== rtl/rmc_arith.sv =====
`default_nettype none

module rmc_arith #(
   parameter int unsigned VALUE_WIDTH = rmc_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rmc_pkg::arith_req_type    arith_req,
   input  logic [VALUE_WIDTH-1:0]    oper_a,
   input  logic [VALUE_WIDTH-1:0]    oper_b,
   output logic                      arith_done,
   output logic [VALUE_WIDTH-1:0]    res_a,
   output logic [VALUE_WIDTH-1:0]    res_b
);
   import rmc_pkg::*;

   localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VALUE_WIDTH);

   typedef enum logic [5:0] {
      U_IDLE  = 6'b000001,
      U_DIV   = 6'b000010,
      U_MUL   = 6'b000100,
      U_GPRE  = 6'b001000,
      U_GCORE = 6'b010000,
      U_GPOST = 6'b100000
   } ustate_type;

   ustate_type             ustate_ff, ustate_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] opb_ff, opb_in;

   logic [VALUE_WIDTH:0]   add_x;
   logic [VALUE_WIDTH:0]   add_y;
   logic                   add_sub;
   logic [VALUE_WIDTH+1:0] add_sum;
   logic                   add_neg;

   // the one adder/subtractor shared by division, multiplication and gcd
   always_comb begin
      priority if (ustate_ff == U_DIV) begin
         add_x   = {acc_ff, quo_ff[VALUE_WIDTH-1]};
         add_y   = {1'b0, opb_ff};
         add_sub = 1'b1;
      end else if (ustate_ff == U_MUL) begin
         add_x   = {acc_ff, 1'b0};
         add_y   = quo_ff[VALUE_WIDTH-1] ? {1'b0, opb_ff} : '0;
         add_sub = 1'b0;
      end else begin
         add_x   = {1'b0, acc_ff};
         add_y   = {1'b0, quo_ff};
         add_sub = 1'b1;
      end
   end

   assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(VALUE_WIDTH+2){add_sub}})
                    + (VALUE_WIDTH+2)'(add_sub);
   assign add_neg = add_sum[VALUE_WIDTH+1];

   always_comb begin
      ustate_in = ustate_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      opb_in    = opb_ff;
      unique case (ustate_ff)
         U_IDLE: begin
            if (arith_req.go) begin
               unique case (arith_req.op)
                  OP_DIV: begin
                     acc_in    = '0;
                     quo_in    = oper_a;
                     opb_in    = oper_b;
                     cnt_in    = CNT_FULL;
                     ustate_in = U_DIV;
                  end
                  OP_MUL: begin
                     acc_in    = '0;
                     quo_in    = oper_a;
                     opb_in    = oper_b;
                     cnt_in    = CNT_FULL;
                     ustate_in = U_MUL;
                  end
                  OP_GCD: begin
                     acc_in    = oper_a;
                     quo_in    = oper_b;
                     cnt_in    = '0;
                     ustate_in = U_GPRE;
                  end
                  default: ustate_in = U_IDLE;
               endcase
            end
         end
         U_DIV: begin
            // restore on borrow, one quotient bit a cycle
            acc_in = add_neg ? add_x[VALUE_WIDTH-1:0] : add_sum[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], ~add_neg};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               ustate_in = U_IDLE;
               done_in   = 1'b1;
            end
         end
         U_MUL: begin
            acc_in = add_sum[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               ustate_in = U_IDLE;
               done_in   = 1'b1;
            end
         end
         U_GPRE: begin
            // strip common factors of two, count them
            if (!acc_ff[0] && !quo_ff[0]) begin
               acc_in = {1'b0, acc_ff[VALUE_WIDTH-1:1]};
               quo_in = {1'b0, quo_ff[VALUE_WIDTH-1:1]};
               cnt_in = cnt_ff + CNT_ONE;
            end else begin
               ustate_in = U_GCORE;
            end
         end
         U_GCORE: begin
            priority if (acc_ff == '0) begin
               if (cnt_ff == '0) begin
                  ustate_in = U_IDLE;
                  done_in   = 1'b1;
               end else begin
                  ustate_in = U_GPOST;
               end
            end else if (!acc_ff[0]) begin
               acc_in = {1'b0, acc_ff[VALUE_WIDTH-1:1]};
            end else if (!quo_ff[0]) begin
               quo_in = {1'b0, quo_ff[VALUE_WIDTH-1:1]};
            end else if (add_neg) begin
               // keep the larger odd value in acc
               acc_in = quo_ff;
               quo_in = acc_ff;
            end else begin
               acc_in = {1'b0, add_sum[VALUE_WIDTH-1:1]};
            end
         end
         U_GPOST: begin
            // restore the common factors of two
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               ustate_in = U_IDLE;
               done_in   = 1'b1;
            end
         end
         default: ustate_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         cnt_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         ustate_ff <= ustate_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      opb_ff <= opb_in;
   end

   assign arith_done = done_ff;
   assign res_a      = acc_ff;
   assign res_b      = quo_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("arith done held longer than one cycle");

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      arith_req.go |-> ustate_ff == U_IDLE)
      else $error("arith operation issued while unit busy");

   a_gcd_operand_live: assert property (@(posedge clock) disable iff (reset)
      ustate_ff == U_GCORE |-> quo_ff != '0)
      else $error("gcd operand reached zero");

   a_step_count_live: assert property (@(posedge clock) disable iff (reset)
      (ustate_ff == U_DIV || ustate_ff == U_MUL || ustate_ff == U_GPOST)
      |-> cnt_ff != '0)
      else $error("step counter empty while iterating");
`endif

endmodule

`default_nettype wire

// ===== rtl/range_multiple_counter.sv =====
`default_nettype none

// channel   ports                                           handshake
// request   req_range_low/high, req_divisor_first/second    start & !busy
// response  rsp_multiple_count                              rsp_valid, one cycle
//
// Every division, the multiply and the gcd run on one shared adder; the divisions
// and the multiply take one bit a cycle. A query ends early when a divisor is zero
// or the lcm exceeds the high bound. busy stays high from acceptance until the response
// beat. Synchronous active-high reset returns to idle; the receiver cannot stall.

module range_multiple_counter #(
   parameter int unsigned VALUE_WIDTH = rmc_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [VALUE_WIDTH-1:0]          req_range_low,
   input  logic [VALUE_WIDTH-1:0]          req_range_high,
   input  logic [VALUE_WIDTH-1:0]          req_divisor_first,
   input  logic [VALUE_WIDTH-1:0]          req_divisor_second,
   output logic                            rsp_valid,
   output logic [rmc_pkg::COUNT_WIDTH-1:0] rsp_multiple_count
);
   import rmc_pkg::*;

   localparam int unsigned CNT_W = VALUE_WIDTH + 2;

   typedef enum logic [10:0] {
      C_IDLE  = 11'b000_0000_0001,
      C_D1_HI = 11'b000_0000_0010,
      C_D1_LO = 11'b000_0000_0100,
      C_D2_HI = 11'b000_0000_1000,
      C_D2_LO = 11'b000_0001_0000,
      C_GCD   = 11'b000_0010_0000,
      C_QUO   = 11'b000_0100_0000,
      C_MUL   = 11'b000_1000_0000,
      C_L_HI  = 11'b001_0000_0000,
      C_L_LO  = 11'b010_0000_0000,
      C_DONE  = 11'b100_0000_0000
   } cstate_type;

   cstate_type             cstate_ff, cstate_in;
   logic                   wait_ff, wait_in;
   logic [VALUE_WIDTH-1:0] lo_ff, lo_in;
   logic [VALUE_WIDTH-1:0] hi_ff, hi_in;
   logic [VALUE_WIDTH-1:0] d1_ff, d1_in;
   logic [VALUE_WIDTH-1:0] d2_ff, d2_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   logic [VALUE_WIDTH-1:0] lcm_ff, lcm_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   arith_req_type          arith_req;
   logic [VALUE_WIDTH-1:0] oper_a;
   logic [VALUE_WIDTH-1:0] oper_b;
   logic                   arith_done;
   logic [VALUE_WIDTH-1:0] res_a;
   logic [VALUE_WIDTH-1:0] res_b;
   logic                   arith_state;
   logic [VALUE_WIDTH:0]   term;

   rmc_arith #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_arith (
      .clock      (clock),
      .reset      (reset),
      .arith_req  (arith_req),
      .oper_a     (oper_a),
      .oper_b     (oper_b),
      .arith_done (arith_done),
      .res_a      (res_a),
      .res_b      (res_b)
   );

   assign arith_state = !(cstate_ff == C_IDLE || cstate_ff == C_DONE);

   // floor(hi/d) - ceil(lo/d) + 1; never negative since lo <= hi
   assign term = {1'b0, top_ff} - {1'b0, res_b}
                 + {{VALUE_WIDTH{1'b0}}, (res_a == '0)};

   always_comb begin
      arith_req.go = arith_state && !wait_ff;
      arith_req.op = OP_DIV;
      oper_a       = hi_ff;
      oper_b       = d1_ff;
      unique case (cstate_ff)
         C_D1_HI: begin
            oper_a = hi_ff;
            oper_b = d1_ff;
         end
         C_D1_LO: begin
            oper_a = lo_ff;
            oper_b = d1_ff;
         end
         C_D2_HI: begin
            oper_a = hi_ff;
            oper_b = d2_ff;
         end
         C_D2_LO: begin
            oper_a = lo_ff;
            oper_b = d2_ff;
         end
         C_GCD: begin
            arith_req.op = OP_GCD;
            oper_a       = d1_ff;
            oper_b       = d2_ff;
         end
         C_QUO: begin
            oper_a = d1_ff;
            oper_b = lcm_ff;
         end
         C_MUL: begin
            arith_req.op = OP_MUL;
            oper_a       = lcm_ff;
            oper_b       = d2_ff;
         end
         C_L_HI: begin
            oper_a = hi_ff;
            oper_b = lcm_ff;
         end
         C_L_LO: begin
            oper_a = lo_ff;
            oper_b = lcm_ff;
         end
         default: begin
            oper_a = hi_ff;
            oper_b = d1_ff;
         end
      endcase
   end

   always_comb begin
      cstate_in = cstate_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      top_in    = top_ff;
      lcm_in    = lcm_ff;
      count_in  = count_ff;
      if (arith_req.go) begin
         wait_in = 1'b1;
      end else if (arith_done) begin
         wait_in = 1'b0;
      end else begin
         wait_in = wait_ff;
      end
      unique case (cstate_ff)
         C_IDLE: begin
            if (start) begin
               // order the bounds
               if (req_range_low > req_range_high) begin
                  lo_in = req_range_high;
                  hi_in = req_range_low;
               end else begin
                  lo_in = req_range_low;
                  hi_in = req_range_high;
               end
               d1_in    = req_divisor_first;
               d2_in    = req_divisor_second;
               count_in = '0;
               priority if (req_divisor_first != '0) begin
                  cstate_in = C_D1_HI;
               end else if (req_divisor_second != '0) begin
                  cstate_in = C_D2_HI;
               end else begin
                  cstate_in = C_DONE;
               end
            end
         end
         C_D1_HI: begin
            if (arith_done) begin
               top_in    = res_b;
               cstate_in = C_D1_LO;
            end
         end
         C_D1_LO: begin
            if (arith_done) begin
               count_in  = count_ff + {1'b0, term};
               cstate_in = (d2_ff != '0) ? C_D2_HI : C_DONE;
            end
         end
         C_D2_HI: begin
            if (arith_done) begin
               top_in    = res_b;
               cstate_in = C_D2_LO;
            end
         end
         C_D2_LO: begin
            if (arith_done) begin
               count_in  = count_ff + {1'b0, term};
               cstate_in = (d1_ff != '0) ? C_GCD : C_DONE;
            end
         end
         C_GCD: begin
            if (arith_done) begin
               lcm_in    = res_b;
               cstate_in = C_QUO;
            end
         end
         C_QUO: begin
            // top holds hi/d2 here: lcm above hi leaves only zero as a common multiple
            if (arith_done) begin
               if (res_b > top_ff) begin
                  count_in  = count_ff - CNT_W'(lo_ff == '0);
                  cstate_in = C_DONE;
               end else begin
                  lcm_in    = res_b;
                  cstate_in = C_MUL;
               end
            end
         end
         C_MUL: begin
            if (arith_done) begin
               lcm_in    = res_a;
               cstate_in = C_L_HI;
            end
         end
         C_L_HI: begin
            if (arith_done) begin
               top_in    = res_b;
               cstate_in = C_L_LO;
            end
         end
         C_L_LO: begin
            if (arith_done) begin
               count_in  = count_ff - {1'b0, term};
               cstate_in = C_DONE;
            end
         end
         C_DONE: cstate_in = C_IDLE;
         default: cstate_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cstate_ff <= C_IDLE;
         wait_ff   <= 1'b0;
      end else begin
         cstate_ff <= cstate_in;
         wait_ff   <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      top_ff   <= top_in;
      lcm_ff   <= lcm_in;
      count_ff <= count_in;
   end

   assign busy               = (cstate_ff != C_IDLE);
   assign rsp_valid          = (cstate_ff == C_DONE);
   assign rsp_multiple_count = COUNT_WIDTH'(count_ff);

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response beat repeated");

   a_go_single: assert property (@(posedge clock) disable iff (reset)
      arith_req.go |=> !arith_req.go)
      else $error("arith operation issued twice");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmc_pkg::*;

   localparam int unsigned VW        = DEFAULT_VALUE_WIDTH;
   localparam int unsigned TAIL_CYCS = 400;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [VW-1:0] req_range_low      = '0;
   logic [VW-1:0] req_range_high     = '0;
   logic [VW-1:0] req_divisor_first  = '0;
   logic [VW-1:0] req_divisor_second = '0;
   logic          rsp_valid;
   logic [COUNT_WIDTH-1:0] rsp_multiple_count;

   logic [COUNT_WIDTH-1:0] pending_counts[$];
   logic [COUNT_WIDTH-1:0] oldest_count;
   int unsigned queries_accepted = 0;
   int unsigned counts_checked   = 0;
   int unsigned zero_div_queries = 0;
   int unsigned error_count      = 0;

   range_multiple_counter #(.VALUE_WIDTH(VW)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_range_low      (req_range_low),
      .req_range_high     (req_range_high),
      .req_divisor_first  (req_divisor_first),
      .req_divisor_second (req_divisor_second),
      .rsp_valid          (rsp_valid),
      .rsp_multiple_count (rsp_multiple_count)
   );

   always #6 clock = ~clock;

   initial begin
      #40_000_000;
      $display("%0t: timeout with %0d counts outstanding", $time, pending_counts.size());
      $display("TEST FAILED");
      $finish;
   end

   // multiples of d in [lo, hi], lo <= hi, d nonzero
   function automatic logic [63:0] multiples_between(input logic [63:0] lo, hi, d);
      logic [63:0] top, bottom;
      top    = hi / d;
      bottom = lo / d + (((lo % d) != 0) ? 64'd1 : 64'd0);
      if (bottom > top) return 64'd0;
      return top - bottom + 64'd1;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] count_multiples(
      input logic [VW-1:0] end_a, end_b, div_a, div_b);
      logic [63:0] lo, hi, d1, d2, t1, t2, t12, x, y, r, q, sum;
      lo  = 64'(end_a);
      hi  = 64'(end_b);
      d1  = 64'(div_a);
      d2  = 64'(div_b);
      t1  = 64'd0;
      t2  = 64'd0;
      t12 = 64'd0;
      if (lo > hi) begin
         x  = lo;
         lo = hi;
         hi = x;
      end
      if (d1 != 0) t1 = multiples_between(lo, hi, d1);
      if (d2 != 0) t2 = multiples_between(lo, hi, d2);
      if (d1 != 0 && d2 != 0) begin
         x = d1;
         y = d2;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         q = d1 / x;
         // lcm beyond the high end: only zero can be a common multiple
         if (q > hi / d2) t12 = (lo == 0) ? 64'd1 : 64'd0;
         else t12 = multiples_between(lo, hi, q * d2);
      end
      sum = t1 + t2 - t12;
      return sum[COUNT_WIDTH-1:0];
   endfunction

   // check each response beat against the oldest prediction, then record new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_counts.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_multiple_count);
               error_count++;
            end else begin
               oldest_count = pending_counts.pop_front();
               counts_checked++;
               if (rsp_multiple_count !== oldest_count) begin
                  $display("%0t: multiple_count mismatch, expected %0d, actual %0d",
                           $time, oldest_count, rsp_multiple_count);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            pending_counts.push_back(count_multiples(req_range_low, req_range_high,
                                                     req_divisor_first, req_divisor_second));
            queries_accepted++;
            if (req_divisor_first == 0 || req_divisor_second == 0) zero_div_queries++;
         end
      end
   end

   // value of random width, so small and full-scale operands both turn up
   function automatic logic [VW-1:0] rand_operand();
      int unsigned w;
      w = $urandom_range(1, VW);
      return VW'($urandom >> (32 - w));
   endfunction

   task automatic send_query(input logic [VW-1:0] lo, hi, d1, d2, input bit no_gap);
      int unsigned gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_range_low      <= lo;
      req_range_high     <= hi;
      req_divisor_first  <= d1;
      req_divisor_second <= d2;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // hold off the sender until every outstanding count has come back
   task automatic wait_for_counts();
      start <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_queries();
      logic [VW-1:0] mx;
      mx = '1;
      send_query(0, 0, 1, 1, 1'b0);
      send_query(0, mx, 1, 1, 1'b0);         // largest possible count
      send_query(mx, 0, 1, 2, 1'b0);         // reversed bounds
      send_query(mx, mx, mx, mx, 1'b0);
      send_query(0, mx, mx, mx - 1, 1'b0);   // lcm past the top, zero in range
      send_query(5, mx, mx, mx - 1, 1'b0);   // lcm past the top, zero outside
      send_query(0, 100, 0, 7, 1'b0);
      send_query(0, 100, 7, 0, 1'b0);
      send_query(0, 100, 0, 0, 1'b0);
      send_query(0, 0, 0, 0, 1'b0);
      send_query(7, 7, 0, 0, 1'b0);
      send_query(10, 10, 3, 5, 1'b0);
      send_query(15, 15, 3, 5, 1'b0);
      send_query(1, 100, 6, 4, 1'b0);
      send_query(100, 1, 6, 4, 1'b0);
      send_query(0, mx, 2, 3, 1'b0);
      send_query(1, mx, 65536, 65536, 1'b0);
      send_query(0, 12, 12, 12, 1'b0);
      send_query(13, 13, mx, 1, 1'b0);
      send_query(mx, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
   endtask

   task automatic test_back_to_back(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_query(rand_operand(), rand_operand(), rand_operand(), rand_operand(), 1'b1);
   endtask

   task automatic test_random_mixed(input int unsigned n);
      logic [VW-1:0] d1, d2;
      for (int unsigned i = 0; i < n; i++) begin
         d1 = rand_operand();
         d2 = rand_operand();
         // drop a divisor to zero now and then
         if ($urandom_range(0, 31) == 0) d1 = '0;
         if ($urandom_range(0, 31) == 0) d2 = '0;
         send_query(rand_operand(), rand_operand(), d1, d2, 1'b0);
      end
   endtask

   // divisors with a common factor, so the lcm term often lands inside the range
   task automatic test_shared_factors(input int unsigned n);
      logic [VW-1:0] g, a, b;
      for (int unsigned i = 0; i < n; i++) begin
         g = VW'($urandom_range(1, 1 << $urandom_range(1, 12)));
         a = VW'($urandom_range(1, 1 << $urandom_range(1, 10)));
         b = VW'($urandom_range(1, 1 << $urandom_range(1, 10)));
         send_query(rand_operand(), rand_operand(), g * a, g * b,
                    $urandom_range(0, 1) != 0);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_queries();
      wait_for_counts();
      test_back_to_back(300);
      wait_for_counts();
      test_random_mixed(1000);
      wait_for_counts();
      test_shared_factors(350);

      wait_for_counts();
      repeat (TAIL_CYCS) @(posedge clock);

      $display("covered %0d queries (%0d with a zero divisor), %0d counts checked",
               queries_accepted, zero_div_queries, counts_checked);
      $display("corner bounds, reversed ranges, oversized lcm, shared factors, mixed gaps");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
